### rtl/core/lfu_cache_key_value_unit_macros.svh
// Assertion helpers for the LFU cache key-value unit.
// Both sample on clk and are disabled while arst_n is low.
`ifndef LFU_CACHE_KEY_VALUE_UNIT_MACROS_SVH
`define LFU_CACHE_KEY_VALUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU cache key-value unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int KEY_W          = 32;
	localparam int STAMP_W        = 64;
	localparam int CAP_W          = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// transaction actions
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // latch a new transaction, clear search trackers
		logic rd;      // read the entry at the scan address
		logic commit;  // apply the decision and emit any result
	} lfu_cmd_t;

endpackage

### rtl/core/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accepts a transaction, sweeps all table slots, then commits.
// ----------------------------------------------------------------------------
module lfu_ctrl #(
	parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	output logic                                         busy,
	output lfu_pkg::lfu_cmd_t                            cmd,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr
);

	localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;

	// state and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN:  state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.rd     = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT);
	end

	assign busy    = (state_q != ST_IDLE);
	assign rd_addr = idx_q;

endmodule

### rtl/core/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath: entry table, hit/victim/free trackers, commit and result regs.
// ----------------------------------------------------------------------------
module lfu_dp #(
	parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  lfu_pkg::lfu_cmd_t                            cmd,
	input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
	input  logic                                         action,
	input  logic signed [lfu_pkg::KEY_W-1:0]             key,
	input  logic signed [lfu_pkg::KEY_W-1:0]             value,
	input  logic                                         cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]                    cfg_wdata,
	output logic                                         done,
	output logic                                         found,
	output logic signed [lfu_pkg::KEY_W-1:0]             data
);

	localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = OCC_W > lfu_pkg::CAP_W ? OCC_W : lfu_pkg::CAP_W;
	localparam int KW    = lfu_pkg::KEY_W;
	localparam int SW    = lfu_pkg::STAMP_W;
	localparam int E_W   = SW + COUNT_BITS + 2 * KW;

	// entry field offsets: {stamp, count, value, key}
	localparam int VAL_LO = KW;
	localparam int CNT_LO = 2 * KW;
	localparam int STP_LO = 2 * KW + COUNT_BITS;

	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic [CAPACITY-1:0]       valid_q;
	logic [OCC_W-1:0]          occ_q;
	logic [SW-1:0]             stamp_q;

	logic          act_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] val_q;

	// read pipeline
	logic             chk_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [E_W-1:0]   rdata;

	logic [KW-1:0]         e_key;
	logic [KW-1:0]         e_val;
	logic [COUNT_BITS-1:0] e_cnt;
	logic [SW-1:0]         e_stp;

	// trackers
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [KW-1:0]         hit_val_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  vic_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [SW-1:0]         vic_stp_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// commit decision
	logic                  cap_zero;
	logic                  full;
	logic [CMP_W-1:0]      eff_cap;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [E_W-1:0]        wdata;
	logic                  ins;
	logic                  occ_inc;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [KW-1:0]         wval;

	lfu_ram #(
		.WIDTH(E_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign e_key = rdata[KW-1:0];
	assign e_val = rdata[VAL_LO +: KW];
	assign e_cnt = rdata[CNT_LO +: COUNT_BITS];
	assign e_stp = rdata[STP_LO +: SW];

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// transaction latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			key_q <= key;
			val_q <= value;
		end
	end

	// valid bit travels alongside the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[rd_addr];
		idx_s1 <= rd_addr;
	end

	// search trackers: first hit, LFU victim (oldest on tie), first free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (chk_s1) begin
			if (vld_s1 && !hit_q && e_key == key_q) begin
				hit_q <= 1'b1;
			end
			if (vld_s1 && (!vic_q || e_cnt < vic_cnt_q ||
			    (e_cnt == vic_cnt_q && e_stp < vic_stp_q))) begin
				vic_q <= 1'b1;
			end
			if (!vld_s1 && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_s1) begin
			if (vld_s1 && !hit_q && e_key == key_q) begin
				hit_idx_q <= idx_s1;
				hit_val_q <= e_val;
				hit_cnt_q <= e_cnt;
			end
			if (vld_s1 && (!vic_q || e_cnt < vic_cnt_q ||
			    (e_cnt == vic_cnt_q && e_stp < vic_stp_q))) begin
				vic_idx_q <= idx_s1;
				vic_cnt_q <= e_cnt;
				vic_stp_q <= e_stp;
			end
			if (!vld_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// commit decision
	always_comb begin
		eff_cap  = (CMP_W'(cap_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_q);
		cap_zero = (eff_cap == '0);
		full     = (CMP_W'(occ_q) >= eff_cap);
		cnt_next = (hit_cnt_q == {COUNT_BITS{1'b1}}) ? hit_cnt_q : hit_cnt_q + 1'b1;
		ins      = 1'b0;
		occ_inc  = 1'b0;
		we       = 1'b0;
		waddr    = hit_idx_q;
		wval     = hit_val_q;
		if (cmd.commit) begin
			if (act_q == lfu_pkg::ACT_GET) begin
				we = hit_q;
			end else if (!cap_zero) begin
				if (hit_q) begin
					we   = 1'b1;
					wval = val_q;
				end else if (full) begin
					we    = vic_q;
					ins   = vic_q;
					waddr = vic_idx_q;
				end else begin
					we      = free_q;
					ins     = free_q;
					occ_inc = free_q;
					waddr   = free_idx_q;
				end
			end
		end
		if (ins) begin
			wdata = {stamp_q, COUNT_BITS'(1), val_q, key_q};
		end else begin
			wdata = {stamp_q, cnt_next, wval, key_q};
		end
	end

	// table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			stamp_q <= '0;
		end else begin
			if (ins) begin
				valid_q[waddr] <= 1'b1;
			end
			if (occ_inc) begin
				occ_q <= occ_q + 1'b1;
			end
			if (we) begin
				stamp_q <= stamp_q + 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done  <= 1'b0;
			found <= 1'b0;
			data  <= '1;
		end else begin
			done  <= cmd.commit && (act_q == lfu_pkg::ACT_GET);
			found <= cmd.commit && (act_q == lfu_pkg::ACT_GET) && hit_q;
			data  <= hit_q ? hit_val_q : '1;
		end
	end

endmodule

### rtl/core/lfu_cache_key_value_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_unit
// Key-value store with least-frequently-used replacement over a fixed table.
// ----------------------------------------------------------------------------
//  channel   | handshake       | payload
//  ----------+-----------------+------------------------
//  request   | start / busy    | action, key, value
//  result    | done (strobe)   | found, data
//  config    | cfg_we          | cfg_wdata (capacity)
//
// Each transaction holds busy through one read per table slot via the
// single RAM read port, then a drain state and a commit state.
// A get's result appears on the cycle after commit, for one cycle; puts
// give no result. Reset clears valid bits, occupancy, stamps and sets
// capacity to 16; no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_unit #(
	parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic signed [lfu_pkg::KEY_W-1:0] key,
	input  logic signed [lfu_pkg::KEY_W-1:0] value,
	output logic                             done,
	output logic                             found,
	output logic signed [lfu_pkg::KEY_W-1:0] data,
	input  logic                             cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]        cfg_wdata
);

`include "lfu_cache_key_value_unit_macros.svh"

	localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

	lfu_pkg::lfu_cmd_t cmd;
	logic [IDX_W-1:0]  rd_addr;

	lfu_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.rd_addr(rd_addr)
	);

	lfu_dp #(
		.CAPACITY  (CAPACITY),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.action   (action),
		.key      (key),
		.value    (value),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.found    (found),
		.data     (data)
	);

	// checks
	`LFU_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`LFU_ASSERT_NOW(a_found_done, found, done, "found raised without a result strobe")
	`LFU_ASSERT_NOW(a_miss_data, done && !found, data == 32'hFFFF_FFFF, "miss data not all ones")
	`LFU_ASSERT_NEXT(a_single_done, done, !done, "two results from one transaction")

endmodule

### dv/lfu_cache_key_value_checker.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_checker
// Watches request, config and result ports of the LFU cache unit, predicts
// every get result from its own table model and compares it field by field.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        action,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        done,
	input  logic        found,
	input  logic [31:0] data,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output int          fail_count,
	output int          pending_gets
);
	import lfu_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] USE_MAX = '1;

	typedef struct packed {
		logic        hit;
		logic [31:0] val;
	} lookup_t;

	// shadow table
	logic                      slot_used [SLOTS];
	logic [31:0]               slot_key [SLOTS];
	logic [31:0]               slot_val [SLOTS];
	logic [COUNT_BITS_DEF-1:0] slot_uses [SLOTS];
	logic [STAMP_W-1:0]        slot_age [SLOTS];
	logic [STAMP_W-1:0]        age_now;
	logic [CAP_W-1:0]          cap_reg;
	int                        filled;
	lookup_t                   lookups_due [$];

	assign pending_gets = lookups_due.size();

	// bump use count (saturating) and refresh the stamp
	function automatic void refresh(int s);
		if (slot_uses[s] != USE_MAX)
			slot_uses[s]++;
		slot_age[s] = age_now;
		age_now++;
	endfunction

	// apply one transaction to the shadow table
	function automatic void apply_txn(logic act, logic [31:0] k, logic [31:0] v);
		int hit_at;
		int victim;
		int lim;
		hit_at = -1;
		victim = -1;
		lim = (cap_reg > SLOTS) ? SLOTS : cap_reg;
		for (int i = 0; i < SLOTS; i++)
			if (hit_at < 0 && slot_used[i] && slot_key[i] == k)
				hit_at = i;
		if (act == ACT_GET) begin
			if (hit_at >= 0) begin
				lookups_due.push_back('{1'b1, slot_val[hit_at]});
				refresh(hit_at);
			end else begin
				lookups_due.push_back('{1'b0, 32'hFFFF_FFFF});
			end
			return;
		end
		if (lim == 0)
			return;
		if (hit_at >= 0) begin
			slot_val[hit_at] = v;
			refresh(hit_at);
			return;
		end
		if (filled >= lim) begin
			// lowest count, oldest stamp on ties
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
					(slot_uses[i] == slot_uses[victim] && slot_age[i] < slot_age[victim])))
					victim = i;
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (victim < 0 && !slot_used[i])
					victim = i;
			if (victim >= 0)
				filled++;
		end
		if (victim < 0)
			return;
		slot_used[victim] = 1'b1;
		slot_key[victim]  = k;
		slot_val[victim]  = v;
		slot_uses[victim] = COUNT_BITS_DEF'(1);
		slot_age[victim]  = age_now;
		age_now++;
	endfunction

	// sample transactions and results
	always @(posedge clk or negedge arst_n) begin
		lookup_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
				slot_val[i]  = '0;
				slot_uses[i] = '0;
				slot_age[i]  = '0;
			end
			age_now = '0;
			cap_reg = CAP_RESET;
			filled = 0;
			fail_count = 0;
			lookups_due.delete();
		end else begin
			if (done) begin
				if (lookups_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: found=%0b data=%h", found, data);
				end else begin
					exp_r = lookups_due.pop_front();
					if (found !== exp_r.hit || data !== exp_r.val) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp found=%0b data=%h, got found=%0b data=%h",
								exp_r.hit, exp_r.val, found, data);
					end
				end
			end
			if (cfg_we)
				cap_reg = cfg_wdata;
			if (start && !busy)
				apply_txn(action, key, value);
		end
	end
endmodule

### dv/tb_lfu_cache_key_value_unit.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_key_value_unit
// Drives directed and random get/put traffic across capacity settings into
// the LFU cache unit; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lfu_cache_key_value_unit;
	import lfu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [31:0] key;
	logic [31:0] value;
	logic        done;
	logic        found;
	logic [31:0] data;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	int          fail_count;
	int          pending_gets;
	bit          steady;
	logic [31:0] key_pool [8];

	lfu_cache_key_value_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key(key), .value(value),
		.done(done), .found(found), .data(data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	lfu_cache_key_value_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key(key), .value(value),
		.done(done), .found(found), .data(data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_gets(pending_gets)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	// issue one transaction, with optional idle gap first; start is raised
	// only at a falling edge where busy is low, so the next rising edge accepts
	task automatic issue(logic act, logic [31:0] k, logic [31:0] v);
		if (!steady)
			while ($urandom_range(99) < 34)
				@(negedge clk);
		while (busy)
			@(negedge clk);
		start  <= 1'b1;
		action <= act;
		key    <= k;
		value  <= v;
		@(negedge clk);
		start <= 1'b0;
	endtask

	// wait for the unit to go quiet, then write capacity
	task automatic set_capacity(logic [4:0] c);
		while (pending_gets != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random transaction mostly over a small key pool to force hits and evictions
	task automatic random_txn();
		logic [31:0] k;
		k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
		issue(1'($urandom_range(1)), k, $urandom());
	endtask

	initial begin
		logic [4:0] caps [6];
		caps = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd7};
		start = 0; action = 0; key = 0; value = 0; cfg_we = 0; cfg_wdata = 0;
		steady = 0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: miss on empty, extremes, update, fill and evict
		issue(ACT_GET, 32'h0000_0000, 32'h0);
		issue(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(ACT_GET, 32'h8000_0000, 32'h0);
		issue(ACT_GET, 32'h7FFF_FFFF, 32'h0);
		issue(ACT_PUT, 32'h8000_0000, 32'h0000_0000);
		issue(ACT_GET, 32'h8000_0000, 32'h0);
		issue(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		set_capacity(5'd2);
		issue(ACT_PUT, 32'h1234_5678, 32'h5555_AAAA);
		issue(ACT_GET, 32'h7FFF_FFFF, 32'h0);
		issue(ACT_GET, 32'h1234_5678, 32'h0);
		set_capacity(5'd0);
		issue(ACT_PUT, 32'h1234_5678, 32'hAAAA_5555);
		issue(ACT_PUT, 32'h0BAD_F00D, 32'h1);
		issue(ACT_GET, 32'h1234_5678, 32'h0);
		issue(ACT_GET, 32'h0BAD_F00D, 32'h0);

		// random phases across capacities
		for (int ph = 0; ph < 6; ph++) begin
			set_capacity(caps[ph]);
			for (int i = 0; i < 8; i++)
				key_pool[i] = (ph[0]) ? $urandom() : $urandom_range(20);
			steady = (ph == 2);
			for (int n = 0; n < 155; n++) begin
				random_txn();
				// sender holds off until all results are back
				if (n == 77)
					while (pending_gets != 0)
						@(negedge clk);
			end
		end
		steady = 0;

		// drain
		while (pending_gets != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
